// ===== rtl/one_at_a_time_hash_bucket_defines.svh =====
`ifndef ONE_AT_A_TIME_HASH_BUCKET_DEFINES_SVH
`define ONE_AT_A_TIME_HASH_BUCKET_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define OAATHB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oaathb check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define OAATHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oaathb check failed");

`endif

// ===== rtl/oaathb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oaathb_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [31:0] BUCKET_COUNT_RESET = 32'd4096;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] full_hash;
    logic [31:0] bucket_index;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIN1,
    BK_FIN2,
    BK_FIN3,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/oaathb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaathb_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [31:0]                wr_data,
  input  wire logic                       rd_en,
  output      logic [31:0]                rd_data,
  output      oaathb_pkg::fifo_status_t   status
);
  import oaathb_pkg::*;

  logic [31:0]      slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign do_wr   = wr_en && !status.full;
  assign do_rd   = rd_en && !status.empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/oaathb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaathb_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire oaathb_pkg::in_item_t     item,
  output      logic                     full,
  input  wire oaathb_pkg::fifo_status_t q_status,
  output      logic                     q_wr,
  output      logic [31:0]              q_data
);
  import oaathb_pkg::*;

  logic [31:0] running_hash;
  logic [31:0] running_hash_next;
  logic [31:0] mixed;
  logic        accept;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;
  assign mixed  = item.has_byte ? mix_byte(running_hash, item.key_byte) : running_hash;

  // a key's last request hands the pre-final value to the back end
  assign q_wr   = accept && item.last_byte;
  assign q_data = mixed;

  always_comb begin
    running_hash_next = running_hash;
    if (accept) begin
      running_hash_next = item.last_byte ? 32'd0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= 32'd0;
    end else begin
      running_hash <= running_hash_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/oaathb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oaathb_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire oaathb_pkg::fifo_status_t q_status,
  input  wire logic [31:0]              q_data,
  output      logic                     q_rd,
  input  wire logic                     cfg_valid,
  input  wire logic [31:0]              cfg_data,
  output      logic                     empty,
  input  wire logic                     pop,
  output      oaathb_pkg::out_item_t    result
);
  import oaathb_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic [31:0] bucket_count;
  logic [31:0] hash;
  logic [31:0] hash_next;
  logic [31:0] dvd;
  logic [31:0] dvd_next;
  logic [31:0] rem;
  logic [31:0] rem_next;
  logic [4:0]  cnt;
  logic [4:0]  cnt_next;
  logic        res_valid;
  logic        load_res;
  logic        out_free;
  logic [32:0] trial;

  assign empty    = !res_valid;
  assign out_free = !res_valid || pop;
  assign trial    = {rem, dvd[31]};

  always_comb begin
    state_next = state;
    hash_next  = hash;
    dvd_next   = dvd;
    rem_next   = rem;
    cnt_next   = cnt;
    q_rd       = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          q_rd       = 1'b1;
          hash_next  = q_data;
          state_next = BK_FIN1;
        end
      end
      BK_FIN1: begin
        hash_next  = hash + (hash << 3);
        state_next = BK_FIN2;
      end
      BK_FIN2: begin
        hash_next  = hash ^ (hash >> 11);
        state_next = BK_FIN3;
      end
      BK_FIN3: begin
        hash_next = hash + (hash << 15);
        dvd_next  = hash_next;
        cnt_next  = 5'd0;
        // zero bucket count leaves the hash unreduced
        if (bucket_count == 32'd0) begin
          rem_next   = hash_next;
          state_next = BK_HOLD;
        end else begin
          rem_next   = 32'd0;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        // one restoring remainder step per cycle, msb first
        if (trial >= {1'b0, bucket_count}) begin
          rem_next = 32'(trial - {1'b0, bucket_count});
        end else begin
          rem_next = trial[31:0];
        end
        dvd_next = dvd << 1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_res   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    hash <= hash_next;
    dvd  <= dvd_next;
    rem  <= rem_next;
    cnt  <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_valid) begin
      bucket_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.full_hash    <= hash;
      result.bucket_index <= rem;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/one_at_a_time_hash_bucket.sv =====
// path from last byte to result: front mix, final mix FIN1-FIN3, bit-serial remainder, load
// throughput: one key byte per cycle at the input while full is low; the back end
//   takes one key at a time in its bit-serial remainder loop, with a 4-entry queue between
// reset (rst, synchronous): running hash 0, queue and result emptied, bucket_count 4096
`timescale 1ns / 1ps
`default_nettype none

module one_at_a_time_hash_bucket (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output      logic                  full,
  input  wire oaathb_pkg::in_item_t  item,
  output      logic                  empty,
  input  wire logic                  pop,
  output      oaathb_pkg::out_item_t result,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [31:0]           cfg_data
);
  import oaathb_pkg::*;

  fifo_status_t q_status;
  logic         q_wr;
  logic [31:0]  q_wdata;
  logic         q_rd;
  logic [31:0]  q_rdata;

  assign cfg_ready = 1'b1;

  oaathb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .q_status (q_status),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  oaathb_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .status  (q_status)
  );

  oaathb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== rtl/oaathb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "one_at_a_time_hash_bucket_defines.svh"

module oaathb_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire oaathb_pkg::out_item_t result,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  // a waiting result that is not taken stays and does not change
  `OAATHB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

  // no result can be waiting right after reset
  `OAATHB_ASSERT_NOW(a_empty_after_reset, $past(rst), empty)

  // the configuration write is never held off
  `OAATHB_ASSERT_NOW(a_cfg_never_blocked, cfg_valid, cfg_ready)

endmodule

bind one_at_a_time_hash_bucket oaathb_checker u_checker (.*);

`default_nettype wire
